### src/stf_pkg.sv
// ----------------------------------------------------------------------------
// stf_pkg: shared types and constants of the scrolling text frame maker
// Glyph geometry, scroll gap and the 96-entry column font for codes 0x20..0x7F.
// ----------------------------------------------------------------------------
package stf_pkg;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int FRAME_W    = GLYPH_COLS * GLYPH_ROWS;
  localparam int COLUMN_GAP = 1;
  localparam int GLYPH_NUM  = 96;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7F;
  localparam logic [7:0] SPACE_CODE = 8'h20;

  // one glyph: element 0 is the leftmost column, bit 0 of a column is the top row
  typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

  localparam glyph_t GLYPH_ROM [GLYPH_NUM] = '{
    {8'h00,8'h00,8'h00,8'h00,8'h00}, {8'h00,8'h00,8'h5F,8'h00,8'h00},
    {8'h00,8'h07,8'h00,8'h07,8'h00}, {8'h14,8'h7F,8'h14,8'h7F,8'h14},
    {8'h24,8'h2A,8'h7F,8'h2A,8'h12}, {8'h23,8'h13,8'h08,8'h64,8'h62},
    {8'h36,8'h49,8'h55,8'h22,8'h50}, {8'h00,8'h05,8'h03,8'h00,8'h00},
    {8'h00,8'h1C,8'h22,8'h41,8'h00}, {8'h00,8'h41,8'h22,8'h1C,8'h00},
    {8'h08,8'h2A,8'h1C,8'h2A,8'h08}, {8'h08,8'h08,8'h3E,8'h08,8'h08},
    {8'h00,8'h50,8'h30,8'h00,8'h00}, {8'h08,8'h08,8'h08,8'h08,8'h08},
    {8'h00,8'h60,8'h60,8'h00,8'h00}, {8'h20,8'h10,8'h08,8'h04,8'h02},
    {8'h3E,8'h51,8'h49,8'h45,8'h3E}, {8'h00,8'h42,8'h7F,8'h40,8'h00},
    {8'h42,8'h61,8'h51,8'h49,8'h46}, {8'h21,8'h41,8'h45,8'h4B,8'h31},
    {8'h18,8'h14,8'h12,8'h7F,8'h10}, {8'h27,8'h45,8'h45,8'h45,8'h39},
    {8'h3C,8'h4A,8'h49,8'h49,8'h30}, {8'h01,8'h71,8'h09,8'h05,8'h03},
    {8'h36,8'h49,8'h49,8'h49,8'h36}, {8'h06,8'h49,8'h49,8'h29,8'h1E},
    {8'h00,8'h36,8'h36,8'h00,8'h00}, {8'h00,8'h56,8'h36,8'h00,8'h00},
    {8'h00,8'h08,8'h14,8'h22,8'h41}, {8'h14,8'h14,8'h14,8'h14,8'h14},
    {8'h41,8'h22,8'h14,8'h08,8'h00}, {8'h02,8'h01,8'h51,8'h09,8'h06},
    {8'h32,8'h49,8'h79,8'h41,8'h3E}, {8'h7E,8'h11,8'h11,8'h11,8'h7E},
    {8'h7F,8'h49,8'h49,8'h49,8'h36}, {8'h3E,8'h41,8'h41,8'h41,8'h22},
    {8'h7F,8'h41,8'h41,8'h22,8'h1C}, {8'h7F,8'h49,8'h49,8'h49,8'h41},
    {8'h7F,8'h09,8'h09,8'h01,8'h01}, {8'h3E,8'h41,8'h41,8'h51,8'h32},
    {8'h7F,8'h08,8'h08,8'h08,8'h7F}, {8'h00,8'h41,8'h7F,8'h41,8'h00},
    {8'h20,8'h40,8'h41,8'h3F,8'h01}, {8'h7F,8'h08,8'h14,8'h22,8'h41},
    {8'h7F,8'h40,8'h40,8'h40,8'h40}, {8'h7F,8'h02,8'h04,8'h02,8'h7F},
    {8'h7F,8'h04,8'h08,8'h10,8'h7F}, {8'h3E,8'h41,8'h41,8'h41,8'h3E},
    {8'h7F,8'h09,8'h09,8'h09,8'h06}, {8'h3E,8'h41,8'h51,8'h21,8'h5E},
    {8'h7F,8'h09,8'h19,8'h29,8'h46}, {8'h46,8'h49,8'h49,8'h49,8'h31},
    {8'h01,8'h01,8'h7F,8'h01,8'h01}, {8'h3F,8'h40,8'h40,8'h40,8'h3F},
    {8'h1F,8'h20,8'h40,8'h20,8'h1F}, {8'h7F,8'h20,8'h18,8'h20,8'h7F},
    {8'h63,8'h14,8'h08,8'h14,8'h63}, {8'h03,8'h04,8'h78,8'h04,8'h03},
    {8'h61,8'h51,8'h49,8'h45,8'h43}, {8'h00,8'h00,8'h7F,8'h41,8'h41},
    {8'h02,8'h04,8'h08,8'h10,8'h20}, {8'h41,8'h41,8'h7F,8'h00,8'h00},
    {8'h04,8'h02,8'h01,8'h02,8'h04}, {8'h40,8'h40,8'h40,8'h40,8'h40},
    {8'h00,8'h01,8'h02,8'h04,8'h00}, {8'h20,8'h54,8'h54,8'h54,8'h78},
    {8'h7F,8'h48,8'h44,8'h44,8'h38}, {8'h38,8'h44,8'h44,8'h44,8'h20},
    {8'h38,8'h44,8'h44,8'h48,8'h7F}, {8'h38,8'h54,8'h54,8'h54,8'h18},
    {8'h08,8'h7E,8'h09,8'h01,8'h02}, {8'h08,8'h14,8'h54,8'h54,8'h3C},
    {8'h7F,8'h08,8'h04,8'h04,8'h78}, {8'h00,8'h44,8'h7D,8'h40,8'h00},
    {8'h20,8'h40,8'h44,8'h3D,8'h00}, {8'h00,8'h7F,8'h10,8'h28,8'h44},
    {8'h00,8'h41,8'h7F,8'h40,8'h00}, {8'h7C,8'h04,8'h18,8'h04,8'h78},
    {8'h7C,8'h08,8'h04,8'h04,8'h78}, {8'h38,8'h44,8'h44,8'h44,8'h38},
    {8'h7C,8'h14,8'h14,8'h14,8'h08}, {8'h08,8'h14,8'h14,8'h18,8'h7C},
    {8'h7C,8'h08,8'h04,8'h04,8'h08}, {8'h48,8'h54,8'h54,8'h54,8'h20},
    {8'h04,8'h3F,8'h44,8'h40,8'h20}, {8'h3C,8'h40,8'h40,8'h20,8'h7C},
    {8'h1C,8'h20,8'h40,8'h20,8'h1C}, {8'h3C,8'h40,8'h30,8'h40,8'h3C},
    {8'h44,8'h28,8'h10,8'h28,8'h44}, {8'h0C,8'h50,8'h50,8'h50,8'h3C},
    {8'h44,8'h64,8'h54,8'h4C,8'h44}, {8'h00,8'h08,8'h36,8'h41,8'h00},
    {8'h00,8'h00,8'h7F,8'h00,8'h00}, {8'h00,8'h41,8'h36,8'h08,8'h00},
    {8'h08,8'h08,8'h2A,8'h1C,8'h08}, {8'h08,8'h1C,8'h2A,8'h08,8'h08}
  };

  // look up a glyph; codes without a glyph draw blank
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    logic [6:0] idx;
    idx = code[6:0] - FIRST_CODE[6:0];
    if (code < FIRST_CODE || code > LAST_CODE) begin
      return '0;
    end
    return GLYPH_ROM[idx];
  endfunction

endpackage

### src/scrolling_text_5x7_frame_maker.sv
// ----------------------------------------------------------------------------
// scrolling_text_5x7_frame_maker: text to 5x7 scroll frames
// Holds one character back and emits five scroll frames per character.
// ----------------------------------------------------------------------------
// Each character of a text is shown as five frames: frame n is the glyph
// shifted left by n columns with the following character sliding in from the
// right after a one-column gap. The first character of a text is only held
// (accepted with no frames); every later character releases the five
// frames of its predecessor, and a final character also releases its own five
// frames, followed by a space. One frame leaves per cycle, paced by the frame
// step counter, while out_stall is low; the input stalls while frames of the
// current character are still to come. The next character is
// accepted in the same cycle as the last frame of the current one; the output
// register decouples the two sides.
module scrolling_text_5x7_frame_maker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stf_pkg::FRAME_W-1:0] out_frame_bits,
  output logic [2:0]                  out_frame_index,
  output logic                        out_end_of_text
);

  localparam logic [3:0] STEP_A_FIRST = 4'd0;
  localparam logic [3:0] STEP_A_LAST  = 4'(stf_pkg::GLYPH_COLS - 1);
  localparam logic [3:0] STEP_B_FIRST = 4'(stf_pkg::GLYPH_COLS);
  localparam logic [3:0] STEP_B_LAST  = 4'(2 * stf_pkg::GLYPH_COLS - 1);
  localparam logic [2:0] LAST_FRAME   = 3'(stf_pkg::GLYPH_COLS - 1);

  // hold state
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;

  // item register: predecessor, current character, last and busy flags, step counter
  logic [7:0] prev_char_r, prev_char_nxt;
  logic [7:0] cur_char_r, cur_char_nxt;
  logic       last_r, last_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] step_r, step_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [stf_pkg::FRAME_W-1:0] frame_bits_r, frame_bits_nxt;
  logic [2:0]                  frame_index_r, frame_index_nxt;
  logic                        end_of_text_r, end_of_text_nxt;

  logic       out_load;
  logic       in_accept;
  logic       step_done;
  logic [3:0] end_step;
  logic       second_part;
  logic [2:0] frame_n;
  logic [7:0] glyph_code;
  logic [7:0] follow_code;
  logic [3:0] follow_start;
  logic       show_follow;
  stf_pkg::glyph_t cur_glyph;
  stf_pkg::glyph_t follow_glyph;

  // handshake
  assign out_load  = !out_valid_r || !out_stall;
  assign end_step  = last_r ? STEP_B_LAST : STEP_A_LAST;
  assign step_done = out_load && (step_r == end_step);
  assign in_stall  = busy_r && !step_done;
  assign in_accept = in_valid && !in_stall;

  // select which character this step draws
  assign second_part = (step_r >= STEP_B_FIRST);
  assign frame_n     = second_part ? 3'(step_r - STEP_B_FIRST) : step_r[2:0];
  assign glyph_code  = second_part ? cur_char_r : prev_char_r;
  assign follow_code = second_part ? stf_pkg::SPACE_CODE : cur_char_r;

  assign cur_glyph    = stf_pkg::glyph_lookup(glyph_code);
  assign follow_glyph = stf_pkg::glyph_lookup(follow_code);
  assign follow_start = 4'(stf_pkg::GLYPH_COLS) - {1'b0, frame_n}
                        + 4'(stf_pkg::COLUMN_GAP);
  assign show_follow  = ({1'b0, frame_n} > 4'(stf_pkg::COLUMN_GAP));

  // build each display column of the frame
  for (genvar x = 0; x < stf_pkg::GLYPH_COLS; x++) begin : g_col
    logic [3:0] cur_idx;
    logic [3:0] follow_idx;
    logic [stf_pkg::GLYPH_ROWS-1:0] col;

    assign cur_idx    = 4'(x) + {1'b0, frame_n};
    assign follow_idx = 4'(x) - follow_start;

    always_comb begin
      priority if (cur_idx < 4'(stf_pkg::GLYPH_COLS)) begin
        col = cur_glyph[cur_idx[2:0]][stf_pkg::GLYPH_ROWS-1:0];
      end else if (show_follow && (4'(x) >= follow_start)) begin
        col = follow_glyph[follow_idx[2:0]][stf_pkg::GLYPH_ROWS-1:0];
      end else begin
        col = '0;
      end
    end

    assign frame_bits_nxt[x*stf_pkg::GLYPH_ROWS +: stf_pkg::GLYPH_ROWS] = col;
  end

  assign frame_index_nxt = frame_n;
  assign end_of_text_nxt = second_part && (frame_n == LAST_FRAME);

  // next state of hold and item register
  always_comb begin
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    prev_char_nxt  = prev_char_r;
    cur_char_nxt   = cur_char_r;
    last_nxt       = last_r;
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r;

    // present a frame whenever the output register is free and an item is busy
    if (out_load) begin
      out_valid_nxt = busy_r;
    end

    // advance the frame step, drop the item after its last frame
    if (busy_r && out_load) begin
      if (step_done) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end

    // take a new character beat
    if (in_accept) begin
      prev_char_nxt = held_char_r;
      cur_char_nxt  = in_char_code;
      last_nxt      = in_last_char;
      busy_nxt      = held_valid_r || in_last_char;
      step_nxt      = held_valid_r ? STEP_A_FIRST : STEP_B_FIRST;
      if (in_last_char) begin
        held_char_nxt  = '0;
        held_valid_nxt = 1'b0;
      end else begin
        held_char_nxt  = in_char_code;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      busy_r       <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      busy_r       <= busy_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_char_r <= prev_char_nxt;
    cur_char_r  <= cur_char_nxt;
    last_r      <= last_nxt;
    if (out_load) begin
      frame_bits_r  <= frame_bits_nxt;
      frame_index_r <= frame_index_nxt;
      end_of_text_r <= end_of_text_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_bits  = frame_bits_r;
  assign out_frame_index = frame_index_r;
  assign out_end_of_text = end_of_text_r;

endmodule

### src/stf_checker.sv
// ----------------------------------------------------------------------------
// stf_checker: port-level checks of the scrolling text frame maker
// Watches the result channel for frame order and a held stalled beat, and the input stall.
// ----------------------------------------------------------------------------
module stf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [stf_pkg::FRAME_W-1:0] out_frame_bits,
  input logic [2:0]                  out_frame_index,
  input logic                        out_end_of_text
);

  localparam logic [2:0] LAST_FRAME = 3'(stf_pkg::GLYPH_COLS - 1);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_bits)
      && $stable(out_frame_index) && $stable(out_end_of_text))
    else $error("stalled result beat changed");

  // frame steps stay within one character
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_index <= LAST_FRAME)
    else $error("frame index out of range");

  // end of text only on the last scroll step
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_frame_index == LAST_FRAME)
    else $error("end of text before last frame");

  // the frames of one character follow without a gap
  a_index_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_frame_index != LAST_FRAME) |=>
      out_valid && (out_frame_index == $past(out_frame_index) + 3'd1))
    else $error("frame sequence broken");

  // the input side is busy while frames of a character are still to come
  a_stall_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && (out_frame_index != LAST_FRAME) |-> in_stall)
    else $error("input taken in the middle of a character");

endmodule

bind scrolling_text_5x7_frame_maker stf_checker u_stf_checker (.*);
